// ----- hdl/bounded_back_forward_history_core_assert.svh -----
// Assertion macros shared by the history core.
`ifndef BOUNDED_BACK_FORWARD_HISTORY_CORE_ASSERT_SVH
`define BOUNDED_BACK_FORWARD_HISTORY_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBFH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBFH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bbfh_pkg.sv -----
package bbfh_pkg;

   localparam int HISTORY_DEPTH = 64;
   localparam int IDX_W         = $clog2(HISTORY_DEPTH);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   localparam int DOC_W   = 32;
   localparam int LINE_W  = 20;
   localparam int COL_W   = 16;
   localparam int POS_W   = 6;
   localparam int DEPTH_W = 7;

   typedef enum logic [1:0] {
      MODE_GOTO    = 2'd0,
      MODE_BACK    = 2'd1,
      MODE_FORWARD = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [DOC_W-1:0]  doc_handle;
      logic [LINE_W-1:0] line_number;
      logic [COL_W-1:0]  column_number;
   } req_word_type;

   typedef struct packed {
      logic               accepted;
      logic               event_fired;
      logic               has_current;
      logic [DOC_W-1:0]   cur_doc;
      logic [LINE_W-1:0]  cur_line;
      logic [COL_W-1:0]   cur_column;
      logic [POS_W-1:0]   position;
      logic [DEPTH_W-1:0] depth_used;
      logic               can_back;
      logic               can_forward;
   } rsp_word_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch_req;
      logic execute;
      logic load_cur;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_fetch;
   } dp_status_type;

endpackage

// ----- hdl/bbfh_if.sv -----
interface bbfh_req_if import bbfh_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bbfh_rsp_if import bbfh_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/bbfh_ctrl.sv -----
module bbfh_ctrl import bbfh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequence one word: take it, run it, load the new entry after a successful move, publish
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.need_fetch ? ST_FETCH : ST_PUBLISH;
         end
         ST_FETCH: begin
            cmd.load_cur = 1'b1;
            state_in     = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until it is taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Refuse words while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/bbfh_datapath.sv -----
module bbfh_datapath import bbfh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_word_type  req_word,
   output rsp_word_type  rsp_word
);

   localparam int ENTRY_W = DOC_W + LINE_W + COL_W;

   typedef struct packed {
      logic [DOC_W-1:0]  doc;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } entry_type;

   // Ring storage, no reset: only written slots are ever loaded as the current entry
   logic [ENTRY_W-1:0] ring_mem [HISTORY_DEPTH];

   req_word_type     req_ff;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] offset_ff, offset_in;
   entry_type        cur_ff;
   entry_type        rd_ff;
   logic             ok_ff, ok_in;
   logic             ev_ff, ev_in;
   rsp_word_type     rsp_ff, rsp_in;

   entry_type        req_entry;
   logic             has_cur;
   logic             dup;
   logic [CNT_W-1:0] base_count;
   logic             at_full;
   logic [IDX_W-1:0] wr_off;
   logic [IDX_W-1:0] wr_slot;
   logic [IDX_W-1:0] rd_slot;
   logic             wr_en;
   logic             fetch;
   logic             can_back;
   logic             can_fwd;

   // Ring slot of an offset from the oldest entry
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(HISTORY_DEPTH)) begin
         sum = sum - (IDX_W+1)'(HISTORY_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_entry = '{doc: req_ff.doc_handle, line: req_ff.line_number,
                        column: req_ff.column_number};
   assign has_cur   = (count_ff != '0);
   assign dup       = has_cur && (cur_ff == req_entry);
   assign can_back  = has_cur && (offset_ff != '0);
   assign can_fwd   = has_cur && ((CNT_W'(offset_ff) + CNT_W'(1)) < count_ff);

   // Go-to drops the forward entries and appends after current
   assign base_count = has_cur ? (CNT_W'(offset_ff) + CNT_W'(1)) : '0;
   assign at_full    = (base_count == CNT_W'(HISTORY_DEPTH));
   assign wr_off     = at_full ? '0 : base_count[IDX_W-1:0];
   assign wr_slot    = slot_of(oldest_ff, wr_off);

   // Decode the operation against the current pointers
   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      ok_in     = 1'b0;
      ev_in     = 1'b0;
      wr_en     = 1'b0;
      fetch     = 1'b0;
      case (mode_type'(req_ff.mode))
         MODE_GOTO: begin
            if (!dup) begin
               wr_en = 1'b1;
               ok_in = 1'b1;
               ev_in = 1'b1;
               if (at_full) begin
                  // evict the oldest entry
                  count_in  = CNT_W'(HISTORY_DEPTH);
                  oldest_in = slot_of(oldest_ff, IDX_W'(1));
                  offset_in = IDX_W'(HISTORY_DEPTH - 1);
               end else begin
                  count_in  = base_count + CNT_W'(1);
                  offset_in = base_count[IDX_W-1:0];
               end
            end
         end
         MODE_BACK: begin
            if (can_back) begin
               offset_in = offset_ff - IDX_W'(1);
               fetch     = 1'b1;
               ok_in     = 1'b1;
               ev_in     = 1'b1;
            end
         end
         MODE_FORWARD: begin
            if (can_fwd) begin
               offset_in = offset_ff + IDX_W'(1);
               fetch     = 1'b1;
               ok_in     = 1'b1;
               ev_in     = 1'b1;
            end
         end
         MODE_CLEAR: begin
            oldest_in = '0;
            count_in  = '0;
            offset_in = '0;
            ok_in     = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign rd_slot           = slot_of(oldest_in, offset_in);
   assign status.need_fetch = fetch;

   // Pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
      end else if (cmd.execute) begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
      end
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         ring_mem[wr_slot] <= req_entry;
      end
      rd_ff <= ring_mem[rd_slot];
   end

   // Hold the word, the current entry and the outcome flags
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_word;
      end
      if (cmd.execute) begin
         ok_ff <= ok_in;
         ev_ff <= ev_in;
      end
      if (cmd.execute && wr_en) begin
         cur_ff <= req_entry;
      end else if (cmd.load_cur) begin
         cur_ff <= rd_ff;
      end
   end

   // Build the result from the state after the operation
   always_comb begin
      rsp_in.accepted    = ok_ff;
      rsp_in.event_fired = ev_ff;
      rsp_in.has_current = has_cur;
      rsp_in.cur_doc     = has_cur ? cur_ff.doc : '0;
      rsp_in.cur_line    = has_cur ? cur_ff.line : '0;
      rsp_in.cur_column  = has_cur ? cur_ff.column : '0;
      rsp_in.position    = has_cur ? POS_W'(offset_ff) : '0;
      rsp_in.depth_used  = DEPTH_W'(count_ff);
      rsp_in.can_back    = can_back;
      rsp_in.can_forward = can_fwd;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- hdl/bounded_back_forward_history_core.sv -----
// Channel  Dir  Handshake            Word
// req_ch   in   valid/ready          mode, doc_handle, line_number, column_number
// rsp_ch   out  valid/ready          accepted .. can_forward, one word per request
//
// Go-to, clear and blocked moves pass from accept through the execute state to
// the publish state; a successful back or forward also passes through a fetch
// state, where the registered ring read is loaded as the new current entry.
// One request is in flight at a time; req_ch.ready is high only while idle.
// A result waiting on rsp_ch does not block the next accept, only its publish.
// Reset is synchronous and clears the pointers; the ring is not cleared.
`include "bounded_back_forward_history_core_assert.svh"

module bounded_back_forward_history_core import bbfh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bbfh_req_if.sink   req_ch,
   bbfh_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   rsp_word_type  rsp_word;

   bbfh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   bbfh_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_ch.payload),
      .rsp_word (rsp_word)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_word;

   // One request at a time
   `BBFH_ASSERT_NEXT(a_single_flight, clock, reset, req_ch.valid && req_ready,
      !req_ready, "second request accepted while busy")

   // An event only comes with an operation that took effect
   `BBFH_ASSERT_IMP(a_event_accepted, clock, reset, rsp_valid && rsp_word.event_fired,
      rsp_word.accepted, "event without accepted operation")

   // Empty history reports zero document, position and depth, and no moves
   `BBFH_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_word.has_current,
      (rsp_word.depth_used == '0) && (rsp_word.position == '0) &&
      (rsp_word.cur_doc == '0) && !rsp_word.can_back && !rsp_word.can_forward,
      "empty history with nonzero fields")

   // Current position lies inside the held depth
   `BBFH_ASSERT_IMP(a_position_range, clock, reset, rsp_valid && rsp_word.has_current,
      (DEPTH_W'(rsp_word.position) < rsp_word.depth_used) &&
      (rsp_word.depth_used <= DEPTH_W'(HISTORY_DEPTH)),
      "position outside held history")

endmodule

// ----- verif/tb_bounded_back_forward_history_core.sv -----
`timescale 1ns / 1ps

module tb_bounded_back_forward_history_core import bbfh_pkg::*; ();

   typedef enum int {
      GAP_NONE,
      GAP_SEND,
      GAP_RECV,
      GAP_BOTH
   } gap_phase_type;

   localparam int RANDOM_WORDS   = 900;
   localparam int PHASE_WORDS    = 100;
   localparam int DRAIN_CYCLES   = 12;
   localparam int TIMEOUT_NS     = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbfh_req_if req_if ();
   bbfh_rsp_if rsp_if ();

   bounded_back_forward_history_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // history mirror
   logic [DOC_W-1:0]  hist_doc  [HISTORY_DEPTH];
   logic [LINE_W-1:0] hist_line [HISTORY_DEPTH];
   logic [COL_W-1:0]  hist_col  [HISTORY_DEPTH];
   int                base_slot;
   int                hist_count;
   int                cur_ofs;

   req_word_type pending_words [$];
   rsp_word_type expected_results [$];

   int  words_sent;
   int  directed_words;
   int  results_checked;
   int  fail_count;
   int  eviction_count;
   int  duplicate_count;
   int  blocked_count;
   bit  req_taken;

   always #5 clock = ~clock;

   // Advance the history mirror by one request word and return the result it gives.
   function automatic rsp_word_type step_history(req_word_type w);
      rsp_word_type r;
      int           slot;
      bit           dup;
      bit           ok;
      bit           ev;
      r   = '0;
      ok  = 1'b0;
      ev  = 1'b0;
      dup = 1'b0;
      case (mode_type'(w.mode))
         MODE_GOTO: begin
            if (hist_count != 0) begin
               slot = (base_slot + cur_ofs) % HISTORY_DEPTH;
               dup  = hist_doc[slot] == w.doc_handle && hist_line[slot] == w.line_number
                      && hist_col[slot] == w.column_number;
            end
            if (dup) begin
               duplicate_count++;
            end else begin
               // drop forward entries, then append after current
               if (hist_count != 0)
                  hist_count = cur_ofs + 1;
               slot = (base_slot + (hist_count % HISTORY_DEPTH)) % HISTORY_DEPTH;
               hist_doc[slot]  = w.doc_handle;
               hist_line[slot] = w.line_number;
               hist_col[slot]  = w.column_number;
               if (hist_count >= HISTORY_DEPTH) begin
                  hist_count = HISTORY_DEPTH;
                  base_slot  = (base_slot + 1) % HISTORY_DEPTH;
                  eviction_count++;
               end else begin
                  hist_count++;
               end
               cur_ofs = hist_count - 1;
               ok = 1'b1;
               ev = 1'b1;
            end
         end
         MODE_BACK: begin
            if (hist_count != 0 && cur_ofs > 0) begin
               cur_ofs--;
               ok = 1'b1;
               ev = 1'b1;
            end else begin
               blocked_count++;
            end
         end
         MODE_FORWARD: begin
            if (hist_count != 0 && cur_ofs + 1 < hist_count) begin
               cur_ofs++;
               ok = 1'b1;
               ev = 1'b1;
            end else begin
               blocked_count++;
            end
         end
         default: begin
            hist_count = 0;
            cur_ofs    = 0;
            base_slot  = 0;
            ok         = 1'b1;
         end
      endcase

      r.accepted    = ok;
      r.event_fired = ev;
      r.has_current = hist_count != 0;
      r.depth_used  = DEPTH_W'(hist_count);
      if (hist_count != 0) begin
         slot          = (base_slot + cur_ofs) % HISTORY_DEPTH;
         r.cur_doc     = hist_doc[slot];
         r.cur_line    = hist_line[slot];
         r.cur_column  = hist_col[slot];
         r.position    = POS_W'(cur_ofs);
         r.can_back    = cur_ofs > 0;
         r.can_forward = cur_ofs + 1 < hist_count;
      end
      return r;
   endfunction

   // Report one field of a result word.
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic gap_phase_type current_gap_phase();
      if (words_sent < directed_words)
         return GAP_NONE;
      return gap_phase_type'(((words_sent - directed_words) / PHASE_WORDS) % 4);
   endfunction

   // Append one word with the given fields; queue_move fills them with random values.
   task automatic queue_word(mode_type m, logic [DOC_W-1:0] doc, logic [LINE_W-1:0] line,
                             logic [COL_W-1:0] col);
      req_word_type w;
      w.mode          = m;
      w.doc_handle    = doc;
      w.line_number   = line;
      w.column_number = col;
      pending_words = {pending_words, w};
   endtask

   task automatic queue_move(mode_type m);
      queue_word(m, $urandom, LINE_W'($urandom), COL_W'($urandom));
   endtask

   // Mix full-range values with a small pool so that revisits repeat locations.
   task automatic queue_random_goto();
      logic [DOC_W-1:0]  doc;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
      case ($urandom_range(3))
         0:       doc = $urandom_range(3);
         1:       doc = $urandom_range(1) ? '1 : '0;
         default: doc = $urandom;
      endcase
      case ($urandom_range(3))
         0:       line = LINE_W'($urandom_range(3));
         1:       line = $urandom_range(1) ? '1 : '0;
         default: line = LINE_W'($urandom);
      endcase
      case ($urandom_range(2))
         0:       col = COL_W'($urandom_range(3));
         default: col = COL_W'($urandom);
      endcase
      queue_word(MODE_GOTO, doc, line, col);
      // repeat the same location now and then to hit the duplicate path
      if ($urandom_range(99) < 12)
         pending_words = {pending_words, pending_words[$]};
   endtask

   // Feed request words from the pending queue.
   always @(negedge clock) begin
      if (!reset && (!req_if.valid || req_taken)) begin
         gap_phase_type ph;
         bit            idle;
         ph = current_gap_phase();
         case (ph)
            GAP_SEND: idle = $urandom_range(99) < 63;
            GAP_BOTH: idle = $urandom_range(99) < 10;
            default:  idle = 1'b0;
         endcase
         if (pending_words.size() != 0 && !idle) begin
            req_if.payload <= pending_words.pop_front();
            req_if.valid   <= 1'b1;
            words_sent     <= words_sent + 1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the result channel according to the phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (current_gap_phase())
            GAP_RECV: rsp_if.ready <= $urandom_range(99) >= 63;
            GAP_BOTH: rsp_if.ready <= $urandom_range(99) >= 10;
            default:  rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // Predict on each accepted request word, check each accepted result word.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready)
            expected_results = {expected_results, step_history(req_if.payload)};
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_word_type want;
            rsp_word_type got;
            got = rsp_if.payload;
            if (expected_results.size() == 0) begin
               $display("%0t: result word with none expected, expected nothing, actual %h",
                        $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("accepted",    want.accepted,    got.accepted);
               check_field("event_fired", want.event_fired, got.event_fired);
               check_field("has_current", want.has_current, got.has_current);
               check_field("cur_doc",     want.cur_doc,     got.cur_doc);
               check_field("cur_line",    want.cur_line,    got.cur_line);
               check_field("cur_column",  want.cur_column,  got.cur_column);
               check_field("position",    want.position,    got.position);
               check_field("depth_used",  want.depth_used,  got.depth_used);
               check_field("can_back",    want.can_back,    got.can_back);
               check_field("can_forward", want.can_forward, got.can_forward);
               results_checked++;
            end
         end
      end
   end

   initial begin
      #TIMEOUT_NS;
      $display("timeout: %0d words pending, %0d results outstanding",
               pending_words.size(), expected_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int random_start;
      int len;
      int pick;

      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      words_sent     = 0;
      directed_words = 0;
      base_slot      = 0;
      hist_count     = 0;
      cur_ofs        = 0;

      // directed: empty history, extremes, duplicates, truncation of forward entries
      queue_move(MODE_BACK);
      queue_move(MODE_FORWARD);
      queue_move(MODE_CLEAR);
      queue_word(MODE_GOTO, '0, '0, '0);
      queue_word(MODE_GOTO, '0, '0, '0);
      queue_word(MODE_GOTO, '1, '1, '1);
      queue_word(MODE_GOTO, '1, '1, '1);
      queue_word(MODE_GOTO, '1, '1, '0);
      queue_word(MODE_GOTO, '1, '0, '1);
      queue_word(MODE_GOTO, '0, '1, '1);
      repeat (5) queue_move(MODE_BACK);
      queue_move(MODE_FORWARD);
      queue_word(MODE_GOTO, 32'h0000_1234, 20'h5, 16'h6);
      queue_move(MODE_FORWARD);
      queue_move(MODE_BACK);
      queue_word(MODE_GOTO, '1, '1, '1);
      queue_move(MODE_CLEAR);
      queue_move(MODE_BACK);
      queue_move(MODE_FORWARD);
      queue_word(MODE_GOTO, 32'hA5A5_A5A5, 20'h5A5A5, 16'hC3C3);
      directed_words = pending_words.size();

      // random: fill past the ring size once, walk to both ends, then mixed scenes
      random_start = pending_words.size();
      repeat (HISTORY_DEPTH + 6) queue_random_goto();
      repeat (HISTORY_DEPTH + 2) queue_move(MODE_BACK);
      repeat (HISTORY_DEPTH + 2) queue_move(MODE_FORWARD);
      while (pending_words.size() - random_start < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(9) == 0) ? $urandom_range(HISTORY_DEPTH + 10, 40)
                                         : $urandom_range(8, 1);
         if (pick < 40) begin
            repeat (len) queue_random_goto();
         end else if (pick < 60) begin
            repeat (len) queue_move(MODE_BACK);
         end else if (pick < 78) begin
            repeat (len) queue_move(MODE_FORWARD);
         end else if (pick < 81) begin
            queue_move(MODE_CLEAR);
         end else begin
            // noise: any mode with any field values
            queue_word(mode_type'($urandom_range(3)), $urandom, LINE_W'($urandom),
                       COL_W'($urandom));
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain stimulus, then all results, then idle before the report
      while (pending_words.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d directed), checked %0d results.",
               words_sent, directed_words, results_checked);
      $display("Saw %0d evictions, %0d duplicate go-to words, %0d blocked moves.",
               eviction_count, duplicate_count, blocked_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
